// ===== sv/fwmc_pkg.sv =====
// Shared types and constants for the framed word message checker.
// Used by fwmc_front, fwmc_fifo, fwmc_back and the top level.
package fwmc_pkg;

    // Frame markers
    localparam logic [31:0] MARK_START = 32'hF0DA_A000;
    localparam logic [31:0] MARK_BEGIN = 32'hF0DA_0000;
    localparam logic [31:0] MARK_END   = 32'hF0DA_0EFF;

    // Clip limit for the error count word
    localparam logic [7:0] MAX_ERRORS = 8'd255;

    // Queue depth and its index width
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ORDER = 2'd1;
    localparam logic [1:0] ST_HASH  = 2'd2;

    // Classified word as it travels from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        is_start;
        logic        is_begin;
        logic        is_end;
        logic        is_zero;
        logic [7:0]  err_count;
    } t_item;

endpackage

// ===== sv/fwmc_front.sv =====
// Front end: takes input beats, decodes markers and clips the error count.
// Depends on fwmc_pkg; pushes classified items into fwmc_fifo.
module fwmc_front (
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  logic [31:0]      i_word,
    input  logic             i_last,
    input  logic             i_fifo_full,
    output logic             o_push,
    output fwmc_pkg::t_item  o_item
);

    // Accept whenever the queue has room
    assign o_s_ready = !i_fifo_full;
    assign o_push    = i_s_valid && !i_fifo_full;

    // Decode the word
    always_comb begin
        o_item.word     = i_word;
        o_item.last     = i_last;
        o_item.is_start = (i_word == fwmc_pkg::MARK_START);
        o_item.is_begin = (i_word == fwmc_pkg::MARK_BEGIN);
        o_item.is_end   = (i_word == fwmc_pkg::MARK_END);
        o_item.is_zero  = (i_word == 32'd0);
        if (i_word <= {24'd0, fwmc_pkg::MAX_ERRORS}) begin
            o_item.err_count = i_word[7:0];
        end else begin
            o_item.err_count = fwmc_pkg::MAX_ERRORS;
        end
    end

endmodule

// ===== sv/fwmc_fifo.sv =====
// Short queue of classified items between the front and the back.
// Depends on fwmc_pkg for the item type and depth.
module fwmc_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fwmc_pkg::t_item  i_item,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output fwmc_pkg::t_item  o_item
);

    localparam int AW = fwmc_pkg::FIFO_AW;
    localparam logic [AW:0] DEPTH = (AW+1)'(fwmc_pkg::FIFO_DEPTH);

    fwmc_pkg::t_item r_mem [fwmc_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [AW:0]   r_count;

    assign o_full  = (r_count == DEPTH);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/fwmc_back.sv =====
// Back end: runs the message structure check and holds the status beat.
// Depends on fwmc_pkg; pops classified items from fwmc_fifo.
module fwmc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  fwmc_pkg::t_item  i_item,
    output logic             o_pop,
    output logic             o_m_valid,
    input  logic             i_m_ready,
    output logic [1:0]       o_status
);

    // Message phases
    localparam logic [2:0] PH_BEGIN  = 3'd0;
    localparam logic [2:0] PH_ID     = 3'd1;
    localparam logic [2:0] PH_ERRNUM = 3'd2;
    localparam logic [2:0] PH_ADDR   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;
    localparam logic [2:0] PH_HASH   = 3'd5;
    localparam logic [2:0] PH_END    = 3'd6;

    logic [2:0]  r_phase,    n_phase;
    logic [7:0]  r_err_exp,  n_err_exp;
    logic [7:0]  r_err_seen, n_err_seen;
    logic [31:0] r_hash,     n_hash;
    logic [1:0]  r_status,   n_status;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic        w_frame_mark;

    // Pop unless a status beat must go out and the output slot is busy
    assign o_pop = !i_empty && (!i_item.last || !r_out_valid || i_m_ready);
    assign o_m_valid = r_out_valid;
    assign o_status  = r_out_status;
    assign w_frame_mark = i_item.is_begin || i_item.is_end;

    // Step the checker on one word
    always_comb begin
        n_phase    = r_phase;
        n_err_exp  = r_err_exp;
        n_err_seen = r_err_seen;
        n_hash     = r_hash;
        n_status   = r_status;
        if (r_status == fwmc_pkg::ST_OK) begin
            case (r_phase)
                PH_BEGIN: begin
                    if (i_item.is_begin) begin
                        n_phase = PH_ID;
                    end else if (!i_item.is_start) begin
                        n_status = fwmc_pkg::ST_ORDER;
                    end
                end
                PH_ID: begin
                    if (w_frame_mark) begin
                        n_status = fwmc_pkg::ST_ORDER;
                    end else begin
                        n_phase = PH_ERRNUM;
                    end
                end
                PH_ERRNUM: begin
                    if (i_item.is_zero || i_item.is_start) begin
                        n_phase = PH_HASH;
                    end else begin
                        n_err_exp = i_item.err_count;
                        n_phase   = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (w_frame_mark) begin
                        n_status = fwmc_pkg::ST_ORDER;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_ERROR: begin
                    if (w_frame_mark) begin
                        n_status = fwmc_pkg::ST_ORDER;
                    end else begin
                        if (r_err_seen < r_err_exp) begin
                            n_phase    = PH_ADDR;
                            n_err_seen = r_err_seen + 8'd1;
                        end
                        if (n_err_seen == r_err_exp) begin
                            n_phase = PH_HASH;
                        end
                    end
                end
                PH_HASH: begin
                    if (i_item.word != r_hash) begin
                        n_status = fwmc_pkg::ST_HASH;
                    end else begin
                        n_phase = PH_END;
                    end
                end
                PH_END: begin
                    if (!i_item.is_end) begin
                        n_status = fwmc_pkg::ST_ORDER;
                    end
                end
                default: begin
                    n_status = fwmc_pkg::ST_ORDER;
                end
            endcase
            // Fold every non-start word up to the error phase into the hash
            if ((r_phase <= PH_ERROR) && !i_item.is_start) begin
                n_hash = r_hash ^ i_item.word;
            end
        end
    end

    // Update message state; clear it after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_BEGIN;
            r_err_exp  <= '0;
            r_err_seen <= '0;
            r_hash     <= '0;
            r_status   <= fwmc_pkg::ST_OK;
        end else if (o_pop) begin
            if (i_item.last) begin
                r_phase    <= PH_BEGIN;
                r_err_exp  <= '0;
                r_err_seen <= '0;
                r_hash     <= '0;
                r_status   <= fwmc_pkg::ST_OK;
            end else begin
                r_phase    <= n_phase;
                r_err_exp  <= n_err_exp;
                r_err_seen <= n_err_seen;
                r_hash     <= n_hash;
                r_status   <= n_status;
            end
        end
    end

    // Hold the status beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_out_status <= n_status;
        end
    end

endmodule

// ===== sv/framed_word_message_checker.sv =====
// Top level of the framed word message checker: front decoder, item queue, checker.
// Depends on fwmc_pkg, fwmc_front, fwmc_fifo and fwmc_back.
//
//   channel  | direction | tdata                   | tlast
//   ---------+-----------+-------------------------+-----------------
//   s_axis   | in        | [31:0] word_in          | last_word
//   m_axis   | out       | [1:0] status, [7:2] 0   | (none)
//
// One input beat per cycle sustained unless a waiting status beat backs up the
// queue; the checker state update (compare, XOR, phase step) is combinational
// on the word at the queue head. The status beat is registered when its last word pops.
// A four-entry queue keeps input flowing while a status beat waits; once a last word
// stalls at the queue head behind it, three more beats fill the queue and input stalls.
// Reset is synchronous, active low, and empties the queue and the output slot.
module framed_word_message_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] word_in
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [1:0] status, [7:2] zero
);

    fwmc_pkg::t_item w_push_item;
    fwmc_pkg::t_item w_head_item;
    logic            w_push;
    logic            w_pop;
    logic            w_full;
    logic            w_empty;
    logic [1:0]      w_status;

    fwmc_front u_front (
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_word      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_fifo_full (w_full),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    fwmc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .o_empty (w_empty),
        .i_pop   (w_pop),
        .o_item  (w_head_item)
    );

    fwmc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_item    (w_head_item),
        .o_pop     (w_pop),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_status  (w_status)
    );

    assign m_axis_tdata = {6'd0, w_status};

endmodule

// ===== bench/tb_framed_word_message_checker.sv =====
`timescale 1ns / 100ps
// Testbench for framed_word_message_checker: queued word stimulus, a clocked driver and monitor,
// and a cycle-free predictor of the message status. Depends on fwmc_pkg and the top level RTL.
module tb_framed_word_message_checker;

    typedef enum logic [2:0] {
        PH_BEGIN, PH_ID, PH_ERRNUM, PH_ADDR, PH_ERROR, PH_HASH, PH_END
    } t_msg_phase;

    typedef enum int {FAULT_NONE, FAULT_HASH, FAULT_MARK} t_fault;

    typedef struct {
        logic [31:0] word;
        logic        last;
        bit          wait_idle;   // hold this beat until every status has come back
    } t_word_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] word_in
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [1:0] status, [7:2] zero

    framed_word_message_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // Predicted checker state
    t_msg_phase  chk_phase = PH_BEGIN;
    logic [7:0]  chk_err_target = '0;
    logic [7:0]  chk_err_seen = '0;
    logic [31:0] chk_hash = '0;
    logic [1:0]  chk_status = fwmc_pkg::ST_OK;

    t_word_beat  pending_beats[$];
    logic [1:0]  expected_status[$];
    t_word_beat  next_beat;

    int mismatches = 0;
    int messages_queued = 0;
    int words_accepted = 0;
    int statuses_checked = 0;
    int status_tally[3] = '{0, 0, 0};
    int tx_gap = 0, tx_calm = 0;
    int rx_gap = 0, rx_calm = 0;
    bit rx_stall = 1'b0;

    // Mostly no gap or short gaps, a few long ones, and calm stretches with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random word biased toward markers and extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 15))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return fwmc_pkg::MARK_START;
            3: return fwmc_pkg::MARK_BEGIN;
            4: return fwmc_pkg::MARK_END;
            default: return $urandom();
        endcase
    endfunction

    // Advance the status prediction by one accepted word; queue a status on the last word
    task automatic track_message_word(input logic [31:0] w, input logic last);
        t_msg_phase prev;
        logic       framing;
        framing = (w == fwmc_pkg::MARK_BEGIN) || (w == fwmc_pkg::MARK_END);
        if (chk_status == fwmc_pkg::ST_OK) begin
            prev = chk_phase;
            case (chk_phase)
                PH_BEGIN: begin
                    if (w == fwmc_pkg::MARK_BEGIN) chk_phase = PH_ID;
                    else if (w != fwmc_pkg::MARK_START) chk_status = fwmc_pkg::ST_ORDER;
                end
                PH_ID: begin
                    if (framing) chk_status = fwmc_pkg::ST_ORDER;
                    else chk_phase = PH_ERRNUM;
                end
                PH_ERRNUM: begin
                    if (w == 32'd0 || w == fwmc_pkg::MARK_START) begin
                        chk_phase = PH_HASH;
                    end else begin
                        chk_err_target = (w <= 32'(fwmc_pkg::MAX_ERRORS)) ?
                                         w[7:0] : fwmc_pkg::MAX_ERRORS;
                        chk_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (framing) chk_status = fwmc_pkg::ST_ORDER;
                    else chk_phase = PH_ERROR;
                end
                PH_ERROR: begin
                    if (framing) begin
                        chk_status = fwmc_pkg::ST_ORDER;
                    end else begin
                        if (chk_err_seen < chk_err_target) begin
                            chk_phase = PH_ADDR;
                            chk_err_seen = chk_err_seen + 8'd1;
                        end
                        if (chk_err_seen == chk_err_target) chk_phase = PH_HASH;
                    end
                end
                PH_HASH: begin
                    if (w != chk_hash) chk_status = fwmc_pkg::ST_HASH;
                    else chk_phase = PH_END;
                end
                PH_END: begin
                    if (w != fwmc_pkg::MARK_END) chk_status = fwmc_pkg::ST_ORDER;
                end
                default: chk_status = fwmc_pkg::ST_ORDER;
            endcase
            if (prev <= PH_ERROR && w != fwmc_pkg::MARK_START) chk_hash ^= w;
        end
        if (last) begin
            expected_status.push_back(chk_status);
            status_tally[chk_status]++;
            chk_phase = PH_BEGIN;
            chk_err_target = '0;
            chk_err_seen = '0;
            chk_hash = '0;
            chk_status = fwmc_pkg::ST_OK;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    task automatic push_beat(input logic [31:0] w, input logic last, input bit wait_idle);
        t_word_beat b;
        b.word = w;
        b.last = last;
        b.wait_idle = wait_idle;
        pending_beats.push_back(b);
    endtask

    // Build one message around a well-formed frame, then damage or cut it as asked
    task automatic queue_message(input int n_start, input logic [31:0] id_word,
                                 input logic [31:0] count_word, input int n_pairs,
                                 input int n_end, input t_fault fault, input int keep_len,
                                 input bit wait_idle);
        logic [31:0] words[$];
        logic [31:0] digest;
        int pos;
        digest = '0;
        repeat (n_start) words.push_back(fwmc_pkg::MARK_START);
        words.push_back(fwmc_pkg::MARK_BEGIN);
        words.push_back(id_word);
        words.push_back(count_word);
        repeat (2 * n_pairs)
            words.push_back(($urandom_range(0, 15) == 0) ? pick_word() : $urandom());
        foreach (words[i])
            if (words[i] != fwmc_pkg::MARK_START) digest ^= words[i];
        if (fault == FAULT_HASH) digest ^= 32'd1 << $urandom_range(0, 31);
        words.push_back(digest);
        repeat (n_end) words.push_back(fwmc_pkg::MARK_END);
        if (fault == FAULT_MARK) begin
            pos = $urandom_range(n_start + 1, words.size() - 1);
            case ($urandom_range(0, 2))
                0: words[pos] = fwmc_pkg::MARK_BEGIN;
                1: words[pos] = fwmc_pkg::MARK_END;
                default: words[pos] = $urandom();
            endcase
        end
        while (keep_len > 0 && words.size() > keep_len) void'(words.pop_back());
        foreach (words[i]) push_beat(words[i], i == words.size() - 1, wait_idle && i == 0);
        messages_queued++;
    endtask

    // Input driver: present queued beats with random gaps, predict on acceptance
    always @(posedge i_clk) begin : drive_words
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_message_word(s_axis_tdata, s_axis_tlast);
                words_accepted++;
                tx_gap = pick_gap(tx_calm);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_beats.size() > 0 &&
                             !(pending_beats[0].wait_idle && expected_status.size() != 0)) begin
                    next_beat = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.word;
                    s_axis_tlast  <= next_beat.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver hold-off: stall the status side for a long stretch, twice
    initial begin : hold_receiver
        wait (statuses_checked >= 10);
        rx_stall = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_stall = 1'b0;
        wait (statuses_checked >= 35);
        rx_stall = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_stall = 1'b0;
    end

    // Status monitor: compare each status beat with the oldest prediction
    always @(posedge i_clk) begin : watch_status
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected status beat", 32'hx, 32'(m_axis_tdata));
                end else begin
                    if (m_axis_tdata[1:0] !== expected_status[0])
                        report_mismatch("status", 32'(expected_status[0]),
                                        32'(m_axis_tdata[1:0]));
                    if (m_axis_tdata[7:2] !== 6'd0)
                        report_mismatch("status padding", 32'd0, 32'(m_axis_tdata[7:2]));
                    void'(expected_status.pop_front());
                end
                statuses_checked++;
                rx_gap = pick_gap(rx_calm);
            end
            if (rx_stall) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin : run_messages
        int sel, pairs, msg_num;
        logic [31:0] count_word;

        // Directed: good frame with start marker and one pair, start marker as count,
        // repeated end markers, bad hash after a drain, failure at the first word,
        // ignored words after a failure, and a short message with a clipped count
        queue_message(1, 32'hFFFF_FFFF, 32'd1, 1, 1, FAULT_NONE, 0, 1'b0);
        queue_message(0, 32'h0000_0000, fwmc_pkg::MARK_START, 0, 2, FAULT_NONE, 0, 1'b0);
        queue_message(0, $urandom(), 32'd0, 0, 0, FAULT_HASH, 0, 1'b1);
        push_beat(32'h0000_0000, 1'b1, 1'b0);
        push_beat(fwmc_pkg::MARK_BEGIN, 1'b0, 1'b0);
        push_beat(fwmc_pkg::MARK_END, 1'b0, 1'b0);
        push_beat($urandom(), 1'b1, 1'b0);
        queue_message(0, $urandom(), 32'hFFFF_FFFF, 2, 1, FAULT_NONE, 4, 1'b0);

        // Random messages, mostly well formed
        msg_num = 0;
        while (pending_beats.size() < 440) begin
            msg_num++;
            sel = $urandom_range(0, 99);
            pairs = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            if (pairs == 0) count_word = $urandom_range(0, 1) ? fwmc_pkg::MARK_START : 32'd0;
            else count_word = 32'(pairs);
            if (sel < 55)
                queue_message($urandom_range(0, 2), pick_word(), count_word, pairs,
                              $urandom_range(0, 2), FAULT_NONE, 0, msg_num % 12 == 5);
            else if (sel < 70)
                queue_message($urandom_range(0, 1), $urandom(), count_word, pairs,
                              $urandom_range(0, 2), FAULT_HASH, 0, msg_num % 12 == 5);
            else if (sel < 82)
                queue_message($urandom_range(0, 1), $urandom(), count_word, pairs,
                              $urandom_range(0, 2), FAULT_MARK, 0, 1'b0);
            else if (sel < 92)
                queue_message($urandom_range(0, 2), pick_word(), pick_word(), pairs,
                              1, FAULT_NONE, $urandom_range(1, 6), 1'b0);
            else begin
                pairs = $urandom_range(1, 6);
                for (int k = 0; k < pairs; k++) push_beat(pick_word(), k == pairs - 1, 1'b0);
                messages_queued++;
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain input, then outstanding statuses, then a short tail
        while (pending_beats.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d status beats from %0d messages, %0d words accepted.",
                 statuses_checked, messages_queued, words_accepted);
        $display("Predicted statuses: %0d ok, %0d order failures, %0d hash mismatches.",
                 status_tally[0], status_tally[1], status_tally[2]);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #1_000_000;
        $display("Timeout with %0d statuses outstanding", expected_status.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== framed_word_message_checker.f =====
sv/fwmc_pkg.sv
sv/fwmc_front.sv
sv/fwmc_fifo.sv
sv/fwmc_back.sv
sv/framed_word_message_checker.sv
bench/tb_framed_word_message_checker.sv
